// File: hdl/tlr_pkg.sv
`timescale 1ns / 1ps

package tlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int THICK_BITS = 6;
    localparam int HALF_BITS  = THICK_BITS - 1;
    localparam int OFF_BITS   = THICK_BITS + 1;

    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

    localparam logic [THICK_BITS-1:0] THICK_RESET = THICK_BITS'(1);

    // action codes carried in tuser
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OUT_BITS-1:0]   t_pix;

    typedef struct packed {
        t_coord first_x;
        t_coord first_y;
        t_coord second_x;
        t_coord second_y;
    } t_line;

    typedef struct packed {
        t_pix pixel_x;
        t_pix pixel_y;
        logic last_pixel;
    } t_pixel;

endpackage

// File: hdl/tlr_core.sv
`timescale 1ns / 1ps

module tlr_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_step,
    input  tlr_pkg::t_line                    i_line,
    input  logic [tlr_pkg::THICK_BITS-1:0]    i_thickness,
    output logic                              o_res_valid,
    output tlr_pkg::t_pixel                   o_res
);
    import tlr_pkg::*;

    typedef logic signed [OFF_BITS-1:0] t_off;
    typedef logic signed [ERR_BITS:0]   t_e2;

    logic                    r_busy;
    t_line                   r_base;
    logic [COORD_BITS-1:0]   r_dx, r_dy;
    logic                    r_sx, r_sy;
    logic signed [ERR_BITS-1:0] r_err;
    t_pix                    r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [THICK_BITS-1:0]   r_idx;
    logic [HALF_BITS-1:0]    r_half;

    // sub-line origin: base shifted by the offset unless that axis is flat
    function automatic t_pix off_pos(input t_coord base, input t_off off,
                                     input logic flat, input logic neg);
        t_pix o;
        begin
            o = flat ? '0 : t_pix'(off);
            off_pos = neg ? (t_pix'(base) - o) : (t_pix'(base) + o);
        end
    endfunction

    // start path
    t_pix                  w_sdx, w_sdy;
    logic [COORD_BITS-1:0] w_adx, w_ady;
    logic [HALF_BITS-1:0]  w_shalf;
    t_off                  w_soff;
    t_e2                   w_sdx_e, w_sdy_e;
    logic                  w_sflat_x, w_sflat_y;

    always_comb begin
        w_sdx     = t_pix'(i_line.second_x) - t_pix'(i_line.first_x);
        w_sdy     = t_pix'(i_line.second_y) - t_pix'(i_line.first_y);
        w_adx     = w_sdx[OUT_BITS-1] ? COORD_BITS'(-w_sdx) : w_sdx[COORD_BITS-1:0];
        w_ady     = w_sdy[OUT_BITS-1] ? COORD_BITS'(-w_sdy) : w_sdy[COORD_BITS-1:0];
        w_sflat_x = (i_line.first_x == i_line.second_x);
        w_sflat_y = (i_line.first_y == i_line.second_y);
        w_shalf   = i_thickness[THICK_BITS-1:1];
        w_soff    = -$signed({2'b00, w_shalf});
        w_sdx_e   = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, w_adx});
        w_sdy_e   = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, w_ady});
    end

    // step path
    t_e2                   w_dx_e, w_dy_e, w_e2, w_err_sum;
    logic                  w_at_end, w_last, w_mv_x, w_mv_y;
    logic [THICK_BITS-1:0] w_idx_nx;
    t_off                  w_noff;
    logic                  w_flat_x, w_flat_y;

    always_comb begin
        w_dx_e    = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, r_dx});
        w_dy_e    = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, r_dy});
        w_e2      = {r_err, 1'b0};
        w_mv_x    = (w_e2 > -w_dy_e);
        w_mv_y    = (w_e2 < w_dx_e);
        w_err_sum = t_e2'(r_err) - (w_mv_x ? w_dy_e : '0) + (w_mv_y ? w_dx_e : '0);
        w_at_end  = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        w_last    = (r_idx >= {r_half, 1'b0});
        w_idx_nx  = r_idx + THICK_BITS'(1);
        w_noff    = $signed({1'b0, w_idx_nx}) - $signed({2'b00, r_half});
        w_flat_x  = (r_dx == '0);
        w_flat_y  = (r_dy == '0);
    end

    assign o_res_valid      = i_step && r_busy;
    assign o_res.pixel_x    = r_cur_x;
    assign o_res.pixel_y    = r_cur_y;
    assign o_res.last_pixel = w_at_end && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_half <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_half <= w_shalf;
        end else if (o_res_valid && w_at_end) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= w_idx_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_base  <= i_line;
            r_dx    <= w_adx;
            r_dy    <= w_ady;
            r_sx    <= !(i_line.first_x < i_line.second_x);
            r_sy    <= !(i_line.first_y < i_line.second_y);
            r_err   <= ERR_BITS'(w_sdx_e - w_sdy_e);
            r_cur_x <= off_pos(i_line.first_x,  w_soff, w_sflat_x, 1'b0);
            r_cur_y <= off_pos(i_line.first_y,  w_soff, w_sflat_y, 1'b1);
            r_tgt_x <= off_pos(i_line.second_x, w_soff, w_sflat_x, 1'b0);
            r_tgt_y <= off_pos(i_line.second_y, w_soff, w_sflat_y, 1'b1);
        end else if (o_res_valid) begin
            if (w_at_end) begin
                if (!w_last) begin
                    r_err   <= ERR_BITS'(w_dx_e - w_dy_e);
                    r_cur_x <= off_pos(r_base.first_x,  w_noff, w_flat_x, 1'b0);
                    r_cur_y <= off_pos(r_base.first_y,  w_noff, w_flat_y, 1'b1);
                    r_tgt_x <= off_pos(r_base.second_x, w_noff, w_flat_x, 1'b0);
                    r_tgt_y <= off_pos(r_base.second_y, w_noff, w_flat_y, 1'b1);
                end
            end else begin
                r_err <= w_err_sum[ERR_BITS-1:0];
                if (w_mv_x) begin
                    r_cur_x <= r_sx ? (r_cur_x - t_pix'(1)) : (r_cur_x + t_pix'(1));
                end
                if (w_mv_y) begin
                    r_cur_y <= r_sy ? (r_cur_y - t_pix'(1)) : (r_cur_y + t_pix'(1));
                end
            end
        end
    end

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_pixel) |=> !r_busy)
        else $error("busy still set after last pixel");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= {r_half, 1'b0}))
        else $error("sub-line index beyond thickness");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !o_res_valid)
        else $error("result while idle");

endmodule

// File: hdl/thick_line_rasterizer_unit.sv
`timescale 1ns / 1ps

// Channel  | Dir | Beat fields (low bit up)
// ---------+-----+----------------------------------------------------------
// s stream | in  | tdata: start_x, start_y, end_x, end_y; tuser: action
// m stream | out | tdata: pixel_x, pixel_y (zero padded); tlast: last_pixel
// cfg      | in  | wr_data: line_thickness, taken when wr_en is high
//
// One input beat per clock while s_tready is high; step pixels leave m registered.
// The step recurrence (error, position, sub-line index) is fed back unpipelined.
// Reset (synchronous, active low) clears busy, the output and skid stages,
// and sets line_thickness to 1.
// s_tready depends only on the skid register, so m stalls never reach s
// combinationally; a full skid holds s off until m drains.

module thick_line_rasterizer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36]
    input  logic [tlr_pkg::IN_DATA_BITS-1:0]    i_s_tdata,
    // action
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // pixel_x[12:0], pixel_y[25:13], zeros above
    output logic [tlr_pkg::OUT_DATA_BITS-1:0]   o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_wr_en,
    input  logic [tlr_pkg::THICK_BITS-1:0]      i_cfg_wr_data
);
    import tlr_pkg::*;

    logic [THICK_BITS-1:0] r_thickness;
    logic                  r_out_valid, r_skid_valid;
    t_pixel                r_out, r_skid;

    logic   w_accept, w_res_valid, w_out_free;
    t_line  w_line;
    t_pixel w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thickness <= THICK_RESET;
        end else if (i_cfg_wr_en) begin
            r_thickness <= i_cfg_wr_data;
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_line.first_x  = i_s_tdata[COORD_BITS-1:0];
    assign w_line.first_y  = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_line.second_x = i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_line.second_y = i_s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    tlr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept && (i_s_tuser == ACTION_START)),
        .i_step      (w_accept && (i_s_tuser == ACTION_STEP)),
        .i_line      (w_line),
        .i_thickness (r_thickness),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output register with skid stage behind it
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_res_valid) begin
            if (w_out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            if (w_out_free) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_out_free && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_BITS-2*OUT_BITS){1'b0}}, r_out.pixel_y, r_out.pixel_x};
    assign o_m_tlast  = r_out.last_pixel;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output is empty");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && r_out_valid && !i_m_tready) |=> r_skid_valid)
        else $error("stalled pixel not parked in skid");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid did not move to output");

endmodule
